>>> rtl/core/spectrum_to_tristimulus_assert.svh
// assertion macros shared by the tristimulus integrator rtl
`ifndef SPECTRUM_TO_TRISTIMULUS_ASSERT_SVH
`define SPECTRUM_TO_TRISTIMULUS_ASSERT_SVH
`ifndef ASSERT_OFF
`define STT_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define STT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define STT_ASSERT(lbl, clk, rst, prop, msg)
`define STT_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

>>> rtl/core/stt_pkg.sv
package stt_pkg;

  localparam int SMP_W  = 16;
  localparam int V_W    = 21;
  localparam int C_W    = V_W + SMP_W;
  localparam int PROD_W = C_W + SMP_W;
  localparam int SUM_W  = 64;
  localparam int NORM_W = 48;
  localparam int Q_W    = 32;
  localparam int DIV_STEPS = Q_W;
  localparam int CNT_W  = $clog2(DIV_STEPS);

  // 100 in q.14
  localparam logic [V_W-1:0] WHITE_V = V_W'(100 << 14);

  typedef enum logic [2:0] {
    MOP_NONE,
    MOP_C,
    MOP_N,
    MOP_X,
    MOP_Y,
    MOP_Z
  } mac_op_t;

  typedef struct packed {
    mac_op_t op;
    logic    clear;
  } mac_ctrl_t;

  typedef enum logic [1:0] {
    DSEL_X,
    DSEL_Y,
    DSEL_Z
  } div_sel_t;

  typedef struct packed {
    logic     start;
    div_sel_t sel;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_C,
    ST_MUL_N,
    ST_MUL_X,
    ST_MUL_Y,
    ST_MUL_Z,
    ST_FLUSH,
    ST_DIV_X,
    ST_DIV_Y,
    ST_DIV_Z,
    ST_OUT
  } state_t;

endpackage

>>> rtl/core/stt_mac.sv
module stt_mac
  import stt_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  mac_ctrl_t         ctrl,
  input  logic [V_W-1:0]    v,
  input  logic [SMP_W-1:0]  il,
  input  logic [SMP_W-1:0]  xm,
  input  logic [SMP_W-1:0]  ym,
  input  logic [SMP_W-1:0]  zm,
  output logic [SUM_W-1:0]  sum_x,
  output logic [SUM_W-1:0]  sum_y,
  output logic [SUM_W-1:0]  sum_z,
  output logic [NORM_W-1:0] sum_norm
);

  logic [C_W-1:0]    mul_a;
  logic [SMP_W-1:0]  mul_b;
  logic [PROD_W-1:0] prod;
  mac_op_t           dest;
  logic [C_W-1:0]    c;
  logic [SUM_W-1:0]  acc_a;
  logic [SUM_W:0]    acc_s;
  logic              sat64;
  logic              sat48;

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctrl.op)
      MOP_C: begin
        mul_a = C_W'(v);
        mul_b = il;
      end
      MOP_N: begin
        mul_a = C_W'(il);
        mul_b = ym;
      end
      MOP_X: begin
        mul_a = c;
        mul_b = xm;
      end
      MOP_Y: begin
        mul_a = c;
        mul_b = ym;
      end
      MOP_Z: begin
        mul_a = c;
        mul_b = zm;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dest <= MOP_NONE;
    end else begin
      dest <= ctrl.op;
    end
  end

  // shared saturating accumulator, adding the registered product in the cycle after the multiplier
  always_comb begin
    case (dest)
      MOP_N:   acc_a = SUM_W'(sum_norm);
      MOP_X:   acc_a = sum_x;
      MOP_Y:   acc_a = sum_y;
      MOP_Z:   acc_a = sum_z;
      default: acc_a = '0;
    endcase
    acc_s = {1'b0, acc_a} + (SUM_W + 1)'(prod);
    sat64 = acc_s[SUM_W];
    sat48 = |acc_s[SUM_W:NORM_W];
  end

  always_ff @(posedge clk) begin
    if (dest == MOP_C) begin
      c <= prod[C_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      sum_x    <= '0;
      sum_y    <= '0;
      sum_z    <= '0;
      sum_norm <= '0;
    end else begin
      case (dest)
        MOP_N: sum_norm <= sat48 ? '1 : acc_s[NORM_W-1:0];
        MOP_X: sum_x    <= sat64 ? '1 : acc_s[SUM_W-1:0];
        MOP_Y: sum_y    <= sat64 ? '1 : acc_s[SUM_W-1:0];
        MOP_Z: sum_z    <= sat64 ? '1 : acc_s[SUM_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/core/stt_div.sv
`include "spectrum_to_tristimulus_assert.svh"

module stt_div
  import stt_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [SUM_W-1:0]  dividend,
  input  logic [NORM_W-1:0] divisor,
  output div_stat_t         stat,
  output logic [Q_W-1:0]    quotient
);

  // floor(4 * dividend / divisor), saturated to 32 bits, one bit per cycle
  logic             active;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [NORM_W-1:0] rem;
  logic [Q_W-1:0]   low;
  logic             ovf;
  logic [NORM_W:0]  shifted;
  logic [NORM_W+1:0] diff;
  logic             ge;

  // quotient overflows exactly when the top part of 4*dividend reaches the divisor
  assign ovf     = NORM_W'(dividend[SUM_W-1:Q_W-2]) >= divisor;
  assign shifted = {rem, low[Q_W-1]};
  assign diff    = {1'b0, shifted} - (NORM_W + 2)'(divisor);
  assign ge      = !diff[NORM_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= !ovf;
        done   <= ovf;
        cnt    <= '0;
      end else if (active) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DIV_STEPS - 1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= NORM_W'(dividend[SUM_W-1:Q_W-2]);
      low      <= {dividend[Q_W-3:0], 2'b00};
      quotient <= ovf ? '1 : '0;
    end else if (active) begin
      rem      <= ge ? diff[NORM_W-1:0] : shifted[NORM_W-1:0];
      low      <= {low[Q_W-2:0], 1'b0};
      quotient <= {quotient[Q_W-2:0], ge};
    end
  end

  assign stat.busy = active;
  assign stat.done = done;

  `STT_ASSERT(a_div_start_progress, clk, rst, start |=> (active || done), "divider lost a start")
  `STT_ASSERT_ALWAYS(a_div_done_idle, clk, done |-> !active, "divider done while still running")

endmodule

>>> rtl/core/spectrum_to_tristimulus.sv
// tristimulus integrator: streams one wavelength sample per transfer on the
// s_ side (tlast marks the final sample of a spectrum) and returns X, Y, Z in
// q16.16 on the m_ side, one transfer per spectrum, with the zero-normaliser
// flag on m_tuser.
// each sample is taken in the idle state and then goes through the shared
// 37x16 multiplier and accumulator (one product per cycle: s*illum, illum*y,
// then the x, y and z terms, plus a flush state to retire the last sum).
// s_tready is high only while the sequencer is idle.
// the final sample adds three divisions on the shared one bit per cycle
// divider before m_tvalid; a zero normaliser skips the divisions, and a
// quotient that saturates is set to all ones without its bit steps.
// the result sits in an output register; the next spectrum is accumulated
// while it waits, and only the next final sample holds off when m_tready
// stays low.
// cfg_data[0] selects the white reference (spectral value 100); write it
// while idle. reset clears the sums, the mode and any pending result.
`include "spectrum_to_tristimulus_assert.svh"

module spectrum_to_tristimulus
  import stt_pkg::*;
#(
  parameter int SAMPLE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data,      // white_reference_mode
  input  logic        s_tvalid,
  output logic        s_tready,
  // spectral_sample, illuminant_sample, x_match, y_match, z_match
  input  logic [79:0] s_tdata,
  input  logic        s_tlast,       // last_sample
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [95:0] m_tdata,       // tri_x, tri_y, tri_z
  output logic        m_tuser        // zero_normaliser
);

  localparam logic [SMP_W-1:0] SampleMask = SMP_W'((32'd1 << SAMPLE_BITS) - 32'd1);

  state_t            state;
  state_t            state_next;
  logic              white;
  logic [V_W-1:0]    v_q;
  logic [SMP_W-1:0]  il_q;
  logic [SMP_W-1:0]  xm_q;
  logic [SMP_W-1:0]  ym_q;
  logic [SMP_W-1:0]  zm_q;
  logic              last_q;
  logic              zero_q;
  logic [Q_W-1:0]    res_x;
  logic [Q_W-1:0]    res_y;
  logic [Q_W-1:0]    res_z;
  logic [SUM_W-1:0]  sum_x;
  logic [SUM_W-1:0]  sum_y;
  logic [SUM_W-1:0]  sum_z;
  logic [NORM_W-1:0] sum_norm;
  logic [SUM_W-1:0]  dividend;
  logic [Q_W-1:0]    quotient;
  mac_ctrl_t         mac_ctrl;
  div_ctrl_t         div_ctrl;
  div_stat_t         div_stat;
  logic              out_free;
  logic              load_out;
  logic              s_xfer;

  assign cfg_ready = 1'b1;
  assign out_free  = !m_tvalid || m_tready;
  assign s_xfer    = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      white <= 1'b0;
    end else if (cfg_valid) begin
      white <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (s_xfer) begin
      v_q    <= white ? WHITE_V : V_W'(s_tdata[15:0] & SampleMask);
      il_q   <= s_tdata[31:16] & SampleMask;
      xm_q   <= s_tdata[47:32] & SampleMask;
      ym_q   <= s_tdata[63:48] & SampleMask;
      zm_q   <= s_tdata[79:64] & SampleMask;
      last_q <= s_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (s_tvalid) state_next = ST_MUL_C;
      ST_MUL_C: state_next = ST_MUL_N;
      ST_MUL_N: state_next = ST_MUL_X;
      ST_MUL_X: state_next = ST_MUL_Y;
      ST_MUL_Y: state_next = ST_MUL_Z;
      ST_MUL_Z: state_next = ST_FLUSH;
      ST_FLUSH: begin
        if (!last_q) begin
          state_next = ST_IDLE;
        end else if (sum_norm == '0) begin
          state_next = ST_OUT;
        end else begin
          state_next = ST_DIV_X;
        end
      end
      ST_DIV_X: if (div_stat.done) state_next = ST_DIV_Y;
      ST_DIV_Y: if (div_stat.done) state_next = ST_DIV_Z;
      ST_DIV_Z: if (div_stat.done) state_next = ST_OUT;
      ST_OUT:   if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready       = 1'b0;
    mac_ctrl.op    = MOP_NONE;
    mac_ctrl.clear = 1'b0;
    div_ctrl.start = 1'b0;
    div_ctrl.sel   = DSEL_X;
    load_out       = 1'b0;
    unique case (state)
      ST_IDLE:  s_tready = 1'b1;
      ST_MUL_C: mac_ctrl.op = MOP_C;
      ST_MUL_N: mac_ctrl.op = MOP_N;
      ST_MUL_X: mac_ctrl.op = MOP_X;
      ST_MUL_Y: mac_ctrl.op = MOP_Y;
      ST_MUL_Z: mac_ctrl.op = MOP_Z;
      ST_FLUSH: begin
        div_ctrl.start = last_q && (sum_norm != '0);
        div_ctrl.sel   = DSEL_X;
      end
      ST_DIV_X: begin
        div_ctrl.start = div_stat.done;
        div_ctrl.sel   = DSEL_Y;
      end
      ST_DIV_Y: begin
        div_ctrl.start = div_stat.done;
        div_ctrl.sel   = DSEL_Z;
      end
      ST_DIV_Z: ;
      ST_OUT: begin
        load_out       = out_free;
        mac_ctrl.clear = out_free;
      end
      default: ;
    endcase
  end

  always_comb begin
    unique case (div_ctrl.sel)
      DSEL_X:  dividend = sum_x;
      DSEL_Y:  dividend = sum_y;
      DSEL_Z:  dividend = sum_z;
      default: dividend = sum_x;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == ST_FLUSH) begin
      zero_q <= (sum_norm == '0);
    end
    if (div_stat.done) begin
      case (state)
        ST_DIV_X: res_x <= quotient;
        ST_DIV_Y: res_y <= quotient;
        ST_DIV_Z: res_z <= quotient;
        default: ;
      endcase
    end
  end

  // output register, holds while the receiver stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= zero_q ? '0 : {res_z, res_y, res_x};
      m_tuser <= zero_q;
    end
  end

  stt_mac u_mac (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (mac_ctrl),
    .v        (v_q),
    .il       (il_q),
    .xm       (xm_q),
    .ym       (ym_q),
    .zm       (zm_q),
    .sum_x    (sum_x),
    .sum_y    (sum_y),
    .sum_z    (sum_z),
    .sum_norm (sum_norm)
  );

  stt_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_ctrl.start),
    .dividend (dividend),
    .divisor  (sum_norm),
    .stat     (div_stat),
    .quotient (quotient)
  );

  `STT_ASSERT(a_start_free, clk, rst, div_ctrl.start |-> !div_stat.busy, "divider started while busy")
  `STT_ASSERT(a_valid_from_out, clk, rst, $rose(m_tvalid) |-> $past(state == ST_OUT), "result without a spectrum end")
  `STT_ASSERT(a_clear_loads, clk, rst, mac_ctrl.clear |=> m_tvalid, "sums cleared without a result")

endmodule
